### hw/rtl/bda_pkg.sv
// Shared types and constants for the box direction angle pipeline.
// Holds the arctangent table in degrees and the stage control struct.
// No dependencies.
package bda_pkg;

  // Angle accumulator: degrees with 16 fraction bits, signed
  localparam int ANGLE_FRAC = 16;
  localparam int ANGLE_W    = 26;
  localparam int DEG_W      = 9;
  localparam int DEG_MAX    = 180;
  localparam int DEG_ZERO   = 90;
  localparam int TABLE_LEN  = 24;

  // atan(2^-i) in degrees, Q16, rounded to nearest
  localparam int ATAN_DEG_Q16 [TABLE_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // Control that travels with each item down the pipeline
  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

endpackage

### hw/rtl/box_direction_angle_degrees.sv
// Bearing in whole degrees from a source box midpoint to a target box midpoint.
// Each item passes from start through the midpoint, quarter-turn, CORDIC and output registers to out_valid.
// Throughput: one item per cycle; busy stays low, each CORDIC iteration is a stage.
// Reset (rst_n low, synchronous) clears every stage valid bit; data regs are not reset.
// Depends on bda_pkg and bda_cordic_stage.
module box_direction_angle_degrees #(
  parameter int COORD_WIDTH  = 20,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COORD_WIDTH-1:0]     in_src_x,
  input  logic signed [COORD_WIDTH-1:0]     in_src_y,
  input  logic        [COORD_WIDTH-2:0]     in_src_w,
  input  logic        [COORD_WIDTH-2:0]     in_src_h,
  input  logic signed [COORD_WIDTH-1:0]     in_dst_x,
  input  logic signed [COORD_WIDTH-1:0]     in_dst_y,
  input  logic        [COORD_WIDTH-2:0]     in_dst_w,
  input  logic        [COORD_WIDTH-2:0]     in_dst_h,
  output logic                              out_valid,
  output logic signed [bda_pkg::DEG_W-1:0]  out_angle_deg
);

  localparam int MW  = COORD_WIDTH + 2;        // 2*pos + size
  localparam int DW  = COORD_WIDTH + 3;        // midpoint difference
  localparam int RW  = COORD_WIDTH + 4;        // after quarter turn
  localparam int XW  = RW + CORDIC_STEPS + 1;  // scaled, plus CORDIC gain
  localparam int ZW  = bda_pkg::ANGLE_W;
  localparam int LAT = CORDIC_STEPS + 3;
  localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(90 << bda_pkg::ANGLE_FRAC);
  localparam logic signed [ZW:0]   Z_HALF    = (ZW+1)'(1 << (bda_pkg::ANGLE_FRAC - 1));
  localparam int DRW = ZW + 1 - bda_pkg::ANGLE_FRAC;
  localparam logic signed [DRW-1:0] DEG_HI = DRW'(bda_pkg::DEG_MAX);
  localparam logic signed [DRW-1:0] DEG_LO = -DRW'(bda_pkg::DEG_MAX);

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---------------- stage 1: midpoint differences ----------------
  logic signed [MW-1:0] src_mx, src_my, dst_mx, dst_my;
  logic signed [DW-1:0] dx_nxt, dy_nxt, dx_r, dy_r;
  bda_pkg::ctl_t        ctl1_r;

  assign src_mx = $signed({in_src_x[COORD_WIDTH-1], in_src_x, 1'b0})
                + $signed({3'b000, in_src_w});
  assign src_my = $signed({in_src_y[COORD_WIDTH-1], in_src_y, 1'b0})
                + $signed({3'b000, in_src_h});
  assign dst_mx = $signed({in_dst_x[COORD_WIDTH-1], in_dst_x, 1'b0})
                + $signed({3'b000, in_dst_w});
  assign dst_my = $signed({in_dst_y[COORD_WIDTH-1], in_dst_y, 1'b0})
                + $signed({3'b000, in_dst_h});
  assign dx_nxt = DW'(dst_mx) - DW'(src_mx);
  assign dy_nxt = DW'(src_my) - DW'(dst_my);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r <= '{valid: accept, zero: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
  end

  // ---------------- stage 2: quarter turn into right half plane ----------------
  logic signed [RW-1:0] rx, ry;
  logic signed [ZW-1:0] z0_nxt;
  logic signed [XW-1:0] x0_r, y0_r;
  logic signed [ZW-1:0] z0_r;
  bda_pkg::ctl_t        ctl2_r;

  always_comb begin
    rx     = RW'(dx_r);
    ry     = RW'(dy_r);
    z0_nxt = '0;
    if (dx_r[DW-1]) begin
      if (!dy_r[DW-1]) begin
        rx     = RW'(dy_r);
        ry     = -RW'(dx_r);
        z0_nxt = Z_QUARTER;
      end else begin
        rx     = -RW'(dy_r);
        ry     = RW'(dx_r);
        z0_nxt = -Z_QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else begin
      ctl2_r <= '{valid: ctl1_r.valid, zero: (dx_r == '0) && (dy_r == '0)};
    end
  end

  always_ff @(posedge clk) begin
    x0_r <= XW'(rx) <<< CORDIC_STEPS;
    y0_r <= XW'(ry) <<< CORDIC_STEPS;
    z0_r <= z0_nxt;
  end

  // ---------------- CORDIC iterations, one stage each ----------------
  logic signed [XW-1:0] x_s [CORDIC_STEPS+1];
  logic signed [XW-1:0] y_s [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_s [CORDIC_STEPS+1];
  bda_pkg::ctl_t        ctl_s [CORDIC_STEPS+1];

  assign x_s[0]   = x0_r;
  assign y_s[0]   = y0_r;
  assign z_s[0]   = z0_r;
  assign ctl_s[0] = ctl2_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    bda_cordic_stage #(
      .XW    (XW),
      .SHIFT (i)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_in  (ctl_s[i]),
      .x_in    (x_s[i]),
      .y_in    (y_s[i]),
      .z_in    (z_s[i]),
      .ctl_out (ctl_s[i+1]),
      .x_out   (x_s[i+1]),
      .y_out   (y_s[i+1]),
      .z_out   (z_s[i+1])
    );
  end

  // ---------------- output: round half away from zero, clamp, 90 for coincident midpoints ----------------
  logic signed [ZW-1:0]  z_fin;
  logic signed [ZW:0]    z_mag_rnd;
  logic signed [DRW-1:0] deg_mag, deg_full;
  logic signed [bda_pkg::DEG_W-1:0] angle_nxt, angle_r;
  logic                  out_valid_r;
  bda_pkg::ctl_t         ctl_fin;

  assign z_fin   = z_s[CORDIC_STEPS];
  assign ctl_fin = ctl_s[CORDIC_STEPS];

  always_comb begin
    if (!z_fin[ZW-1]) begin
      z_mag_rnd = (ZW+1)'(z_fin) + Z_HALF;
    end else begin
      z_mag_rnd = -(ZW+1)'(z_fin) + Z_HALF;
    end
    deg_mag  = DRW'(z_mag_rnd >>> bda_pkg::ANGLE_FRAC);
    deg_full = z_fin[ZW-1] ? -deg_mag : deg_mag;
    if (ctl_fin.zero) begin
      angle_nxt = bda_pkg::DEG_W'(bda_pkg::DEG_ZERO);
    end else if (deg_full > DEG_HI) begin
      angle_nxt = bda_pkg::DEG_W'(DEG_HI);
    end else if (deg_full < DEG_LO) begin
      angle_nxt = bda_pkg::DEG_W'(DEG_LO);
    end else begin
      angle_nxt = bda_pkg::DEG_W'(deg_full);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    angle_r <= angle_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_angle_deg = angle_r;

  // ---------------- assertions ----------------
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("item did not emerge after pipeline latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result without an accepted item");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle_deg <= bda_pkg::DEG_W'(bda_pkg::DEG_MAX)) &&
                  (out_angle_deg >= -bda_pkg::DEG_W'(bda_pkg::DEG_MAX)))
    else $error("angle outside -180..180");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_fin.valid && ctl_fin.zero |=>
      out_angle_deg == bda_pkg::DEG_W'(bda_pkg::DEG_ZERO))
    else $error("coincident midpoints did not give 90");

endmodule

### hw/rtl/bda_cordic_stage.sv
// One registered CORDIC vectoring iteration with a fixed shift.
// Depends on bda_pkg for the arctangent table and the control struct.
// Drives y toward zero and accumulates the turned angle in z.
module bda_cordic_stage #(
  parameter int XW    = 41,
  parameter int SHIFT = 0
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  bda_pkg::ctl_t                          ctl_in,
  input  logic signed [XW-1:0]                   x_in,
  input  logic signed [XW-1:0]                   y_in,
  input  logic signed [bda_pkg::ANGLE_W-1:0]     z_in,
  output bda_pkg::ctl_t                          ctl_out,
  output logic signed [XW-1:0]                   x_out,
  output logic signed [XW-1:0]                   y_out,
  output logic signed [bda_pkg::ANGLE_W-1:0]     z_out
);

  localparam logic signed [bda_pkg::ANGLE_W-1:0] ATAN_STEP =
    bda_pkg::ANGLE_W'(bda_pkg::ATAN_DEG_Q16[SHIFT]);

  logic signed [XW-1:0]               xs, ys;
  logic signed [XW-1:0]               x_nxt, y_nxt;
  logic signed [bda_pkg::ANGLE_W-1:0] z_nxt;
  logic signed [XW-1:0]               x_r, y_r;
  logic signed [bda_pkg::ANGLE_W-1:0] z_r;
  bda_pkg::ctl_t                      ctl_r;

  // Arithmetic shift floors, as the iteration requires
  assign xs = x_in >>> SHIFT;
  assign ys = y_in >>> SHIFT;

  always_comb begin
    if (!y_in[XW-1]) begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + ATAN_STEP;
    end else begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - ATAN_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign ctl_out = ctl_r;
  assign x_out   = x_r;
  assign y_out   = y_r;
  assign z_out   = z_r;

endmodule

### dv/tb.sv
// Self-checking bench for box_direction_angle_degrees: box pairs in, one bearing out per pair.
// Holds its own CORDIC bearing predictor, a queue-fed driver and a strobe monitor.
// Depends on bda_pkg and the box_direction_angle_degrees RTL.
module tb;

  localparam int CW        = 20;
  localparam int STEPS     = 16;
  localparam int LATENCY   = STEPS + 3;
  localparam int N_RANDOM  = 950;
  localparam int CALM_TAIL = 150;

  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-2:0]        S_MAX = '1;

  // atan(2^-i) in degrees, 16 fraction bits
  localparam longint ATAN_TABLE [bda_pkg::TABLE_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct {
    logic signed [CW-1:0] src_x, src_y;
    logic [CW-2:0]        src_w, src_h;
    logic signed [CW-1:0] dst_x, dst_y;
    logic [CW-2:0]        dst_w, dst_h;
    int unsigned          gap;
  } box_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] in_src_x = '0, in_src_y = '0, in_dst_x = '0, in_dst_y = '0;
  logic [CW-2:0]        in_src_w = '0, in_src_h = '0, in_dst_w = '0, in_dst_h = '0;
  logic                 out_valid;
  logic signed [bda_pkg::DEG_W-1:0] out_angle_deg;

  box_pair_t                        pairs_to_send[$];
  logic signed [bda_pkg::DEG_W-1:0] angles_due[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_directed = 0;
  int n_coincident = 0;
  int n_west = 0;
  int n_idle = 0;

  box_direction_angle_degrees #(.COORD_WIDTH(CW), .CORDIC_STEPS(STEPS)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_src_x(in_src_x), .in_src_y(in_src_y), .in_src_w(in_src_w), .in_src_h(in_src_h),
    .in_dst_x(in_dst_x), .in_dst_y(in_dst_y), .in_dst_w(in_dst_w), .in_dst_h(in_dst_h),
    .out_valid(out_valid), .out_angle_deg(out_angle_deg)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bearing from source midpoint to target midpoint, y pointing down
  function automatic logic signed [bda_pkg::DEG_W-1:0] bearing_deg(input box_pair_t p,
                                                                    output bit coincident,
                                                                    output bit west);
    longint dx, dy, x, y, z, t, xs, ys, deg;
    dx = (2 * longint'(p.dst_x) + longint'(p.dst_w)) - (2 * longint'(p.src_x) + longint'(p.src_w));
    dy = (2 * longint'(p.src_y) + longint'(p.src_h)) - (2 * longint'(p.dst_y) + longint'(p.dst_h));
    coincident = (dx == 0 && dy == 0);
    west = (dx < 0);
    if (coincident) return bda_pkg::DEG_W'(bda_pkg::DEG_ZERO);
    x = dx <<< STEPS;
    y = dy <<< STEPS;
    z = 0;
    // turn a leftward vector into the right half plane first
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t;
        z = longint'(90) <<< bda_pkg::ANGLE_FRAC;
      end else begin
        t = x; x = -y; y = t;
        z = -(longint'(90) <<< bda_pkg::ANGLE_FRAC);
      end
    end
    for (int i = 0; i < STEPS && i < bda_pkg::TABLE_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + ATAN_TABLE[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ATAN_TABLE[i];
      end
    end
    if (z >= 0) deg = (z + (longint'(1) <<< (bda_pkg::ANGLE_FRAC - 1))) >>> bda_pkg::ANGLE_FRAC;
    else deg = -((-z + (longint'(1) <<< (bda_pkg::ANGLE_FRAC - 1))) >>> bda_pkg::ANGLE_FRAC);
    if (deg > 180) deg = 180;
    if (deg < -180) deg = -180;
    return deg[bda_pkg::DEG_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    errors++;
  endtask

  task automatic add_pair(input logic signed [CW-1:0] sx, input logic signed [CW-1:0] sy,
                          input logic [CW-2:0] sw, input logic [CW-2:0] sh,
                          input logic signed [CW-1:0] tx, input logic signed [CW-1:0] ty,
                          input logic [CW-2:0] tw, input logic [CW-2:0] th,
                          input int unsigned gap);
    box_pair_t p;
    p.src_x = sx; p.src_y = sy; p.src_w = sw; p.src_h = sh;
    p.dst_x = tx; p.dst_y = ty; p.dst_w = tw; p.dst_h = th;
    p.gap = gap;
    pairs_to_send.push_back(p);
  endtask

  function automatic box_pair_t random_pair(input int unsigned gap);
    box_pair_t p;
    int d;
    p.src_x = CW'($urandom); p.src_y = CW'($urandom);
    p.src_w = (CW-1)'($urandom); p.src_h = (CW-1)'($urandom);
    p.dst_x = CW'($urandom); p.dst_y = CW'($urandom);
    p.dst_w = (CW-1)'($urandom); p.dst_h = (CW-1)'($urandom);
    p.gap = gap;
    case ($urandom_range(0, 9))
      4, 5: begin
        // nearby boxes: small vectors, fine rounding steps
        d = int'($urandom_range(0, 16)) - 8; p.dst_x = CW'(p.src_x + d);
        d = int'($urandom_range(0, 16)) - 8; p.dst_y = CW'(p.src_y + d);
        d = int'($urandom_range(0, 4)) - 2;  p.dst_w = (CW-1)'(p.src_w + d);
        d = int'($urandom_range(0, 4)) - 2;  p.dst_h = (CW-1)'(p.src_h + d);
      end
      6: begin
        p.dst_x = p.src_x; p.dst_w = p.src_w;
      end
      7: begin
        p.dst_y = p.src_y; p.dst_h = p.src_h;
      end
      8: begin
        // same midpoint, sizes traded against positions where they fit
        p.dst_x = p.src_x; p.dst_y = p.src_y; p.dst_w = p.src_w; p.dst_h = p.src_h;
        if (p.src_w >= 2 && p.src_x != C_MAX && $urandom_range(0, 1)) begin
          p.dst_x = CW'(p.src_x + 1); p.dst_w = (CW-1)'(p.src_w - 2);
        end
      end
      9: begin
        // far left with dy near zero: around the +-180 seam
        p.src_x = CW'($urandom_range(0, 1 << (CW - 2)));
        p.dst_x = p.src_x - CW'($urandom_range(1, 1 << (CW - 2)));
        p.dst_y = p.src_y; p.dst_h = p.src_h;
        d = int'($urandom_range(0, 6)) - 3; p.dst_h = (CW-1)'(p.src_h + d);
      end
      default: ;
    endcase
    return p;
  endfunction

  // Driver: present the head item; hold it while busy, idle per its gap
  always @(negedge clk) begin
    if (!rst_n || pairs_to_send.size() == 0) begin
      start <= 1'b0;
    end else if (pairs_to_send[0].gap != 0) begin
      pairs_to_send[0].gap = pairs_to_send[0].gap - 1;
      n_idle++;
      start <= 1'b0;
    end else begin
      in_src_x <= pairs_to_send[0].src_x;
      in_src_y <= pairs_to_send[0].src_y;
      in_src_w <= pairs_to_send[0].src_w;
      in_src_h <= pairs_to_send[0].src_h;
      in_dst_x <= pairs_to_send[0].dst_x;
      in_dst_y <= pairs_to_send[0].dst_y;
      in_dst_w <= pairs_to_send[0].dst_w;
      in_dst_h <= pairs_to_send[0].dst_h;
      start <= 1'b1;
    end
  end

  // Acceptance: predict the bearing of each item the block takes
  always @(posedge clk) begin
    bit coincident, west;
    if (rst_n && start && !busy && pairs_to_send.size() != 0) begin
      angles_due.push_back(bearing_deg(pairs_to_send[0], coincident, west));
      if (coincident) n_coincident++;
      if (west) n_west++;
      n_sent++;
      pairs_to_send.pop_front();
    end
  end

  // Monitor: every strobe must match the oldest pending bearing
  always @(posedge clk) begin
    if (rst_n) begin
      if ($isunknown(out_valid)) begin
        report_mismatch("out_valid is unknown");
      end else if (out_valid) begin
        if (angles_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result angle_deg=%0d", out_angle_deg));
        end else begin
          if (out_angle_deg !== angles_due[0])
            report_mismatch($sformatf("angle_deg got %0d expected %0d",
                                      out_angle_deg, angles_due[0]));
          angles_due.pop_front();
          n_checked++;
        end
      end
    end
  end

  initial begin
    bit calm;
    int unsigned gap;
    // directed: quadrants, axes, seam, extremes of every field
    add_pair('0, '0, '0, '0, '0, '0, '0, '0, 0);
    add_pair('0, '0, '0, '0, CW'(16), '0, '0, '0, 0);
    add_pair('0, '0, '0, '0, -CW'(16), '0, '0, '0, 0);
    add_pair('0, '0, '0, '0, '0, -CW'(16), '0, '0, 2);
    add_pair('0, '0, '0, '0, '0, CW'(16), '0, '0, 0);
    add_pair('0, '0, '0, '0, CW'(16), -CW'(16), '0, '0, 0);
    add_pair('0, '0, '0, '0, -CW'(16), -CW'(16), '0, '0, 1);
    add_pair('0, '0, '0, '0, -CW'(16), CW'(16), '0, '0, 0);
    add_pair('0, '0, '0, '0, CW'(16), CW'(16), '0, '0, 0);
    add_pair('0, '0, '0, '0, C_MIN, '0, '0, (CW-1)'(1), 0);
    add_pair('0, '0, '0, (CW-1)'(1), C_MIN, '0, '0, '0, 3);
    add_pair(C_MIN, C_MIN, S_MAX, S_MAX, C_MAX, C_MAX, S_MAX, S_MAX, 0);
    add_pair(C_MAX, C_MAX, S_MAX, S_MAX, C_MIN, C_MIN, '0, '0, 0);
    add_pair(C_MAX, C_MIN, '0, S_MAX, C_MIN, C_MAX, S_MAX, '0, 0);
    add_pair(C_MIN, C_MAX, S_MAX, '0, C_MAX, C_MIN, '0, S_MAX, 1);
    add_pair('0, '0, (CW-1)'(2), '0, CW'(1), -CW'(1), '0, '0, 0);
    add_pair('0, '0, '0, (CW-1)'(1), '0, '0, (CW-1)'(1), '0, 0);
    add_pair('0, '0, (CW-1)'(1), '0, '0, '0, '0, '0, 0);
    add_pair('0, '0, (CW-1)'(1), '0, '0, '0, '0, (CW-1)'(1), 4);
    add_pair('0, '0, '0, '0, '0, '0, '0, (CW-1)'(1), 0);
    add_pair(C_MAX, C_MAX, S_MAX, S_MAX, C_MAX, C_MAX, S_MAX, S_MAX, 0);
    add_pair(C_MIN, C_MIN, '0, '0, C_MIN, C_MIN, '0, '0, 0);
    add_pair(20'hAAAAA, 20'h55555, 19'h2AAAA, 19'h55555,
             20'h55555, 20'hAAAAA, 19'h55555, 19'h2AAAA, 0);
    n_directed = pairs_to_send.size();

    for (int i = 0; i < N_RANDOM; i++) begin
      // idle in bursts on alternate stretches, none near the end
      calm = ((i / 64) % 2 == 1) || (i >= N_RANDOM - CALM_TAIL);
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
      pairs_to_send.push_back(random_pair(gap));
    end

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pairs_to_send.size() != 0 || angles_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d box pairs (%0d directed), checked %0d bearings, %0d idle cycles.",
             n_sent, n_directed, n_checked, n_idle);
    $display("Coincident midpoints: %0d, leftward vectors: %0d.", n_coincident, n_west);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timed out with %0d items unsent and %0d bearings outstanding.",
             pairs_to_send.size(), angles_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
